/* rtl/dph_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dph_pkg;

    localparam int HASH_W = 64;
    localparam int KEY_W  = 8;
    localparam int IDX_W  = 16;

    localparam logic [HASH_W-1:0] HASH_SEED  = 64'd5381;
    localparam int                MULT_SHIFT = 5;
    localparam logic [IDX_W-1:0]  COUNT_RST  = 16'd1;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } dph_mod_status_t;

endpackage

`default_nettype wire

/* rtl/dph_mod_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module dph_mod_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dph_pkg::HASH_W-1:0]   dividend,
    input  wire logic [dph_pkg::IDX_W-1:0]    divisor,
    output dph_pkg::dph_mod_status_t          status
);
    import dph_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [HASH_W-1:0]   num_reg;
    logic [IDX_W-1:0]    den_reg;
    logic [IDX_W-1:0]    rem_reg;
    logic [IDX_W:0]      trial;
    logic [IDX_W:0]      diff;
    logic [IDX_W-1:0]    rem_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, num_reg[HASH_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = diff[IDX_W-1:0];
        end
        else
        begin
            rem_next = trial[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HASH_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

`default_nettype wire

/* rtl/djb2_partition_hash_core.sv */
// channel   dir  tdata                      tuser  tlast
// s_axis    in   [7:0] key_byte             -      -
// m_axis    out  [15:0] partition_index     -      -
// cfg       in   [15:0] num_parts           -      -
//
// a non-zero key byte is folded into the hash as it is accepted; the next item is taken right after
// a zero byte starts the modulo in the bit-serial remainder unit; once it is done the core
// loads the output register, stalling while a prior result is unread, and then is ready again
// the result sits in an output register; non-zero bytes keep flowing while it waits
// rst_n clears the hash to 5381, the count to 1 and the output valid
`timescale 1ns / 1ps
`default_nettype none

module djb2_partition_hash_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output wire logic                        s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] key_byte
    output wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    output wire logic [15:0]                 m_tdata,   // [15:0] partition_index
    input  wire logic                        cfg_wr_en,
    input  wire logic [dph_pkg::IDX_W-1:0]   cfg_wr_data
);
    import dph_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } state_t;

    state_t             state_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [HASH_W-1:0]  hash_next;
    logic [IDX_W-1:0]   count_reg;
    logic               m_valid_reg;
    logic [IDX_W-1:0]   m_data_reg;
    logic               accept;
    logic               key_end;
    logic               mod_start;
    logic [HASH_W-1:0]  byte_ext;
    logic [IDX_W-1:0]   idx;
    dph_mod_status_t    mod_status;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign key_end   = (s_tdata == '0);
    assign mod_start = accept && key_end;
    assign byte_ext  = {{(HASH_W - KEY_W){s_tdata[KEY_W-1]}}, s_tdata};
    assign hash_next = (hash_reg << MULT_SHIFT) + hash_reg + byte_ext;
    assign idx       = (count_reg == '0) ? '0 : mod_status.rem;

    dph_mod_unit u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_reg),
        .divisor  (count_reg),
        .status   (mod_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hash_reg    <= HASH_SEED;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready && (state_reg != ST_WAIT))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (key_end)
                        begin
                            hash_reg  <= HASH_SEED;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            hash_reg <= hash_next;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (mod_status.done)
                    begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= idx;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/dph_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module dph_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // a key end keeps the input closed while the remainder runs
    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata == 8'd0) |=> !s_tready)
        else $error("input ready right after a key end");

    // a non-zero key byte never raises a result
    a_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata != 8'd0 && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by a non-zero key byte");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output item changed while stalled");

endmodule

bind djb2_partition_hash_core dph_checker u_dph_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
